// ----- rtl/core/hbwd_pkg.sv -----
// Shared types and constants for the heartbeat watchdog with beep-code buzzer.
// No dependencies; imported by heartbeat_watchdog_beep_code.
package hbwd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_PERIOD  = 2'd1;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RST = 16'd200;
    localparam logic [9:0]  PERIOD_RST  = 10'd400;

    // Item kinds carried in the slave-side tuser bit.
    localparam logic MODE_TICK      = 1'b0;
    localparam logic MODE_HEARTBEAT = 1'b1;

    // Width of the scratch arithmetic used for the beep counter.
    localparam int BEEP_MATH_W = 6;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// ----- rtl/core/heartbeat_watchdog_beep_code.sv -----
// Multi-channel heartbeat watchdog that drives a beep-code buzzer.
// Depends on hbwd_pkg for register indexes, reset values and the state type.
// Holds the per-device last-seen timestamps in one synchronous memory.

// A heartbeat transfer (tuser = 1) stores the current millisecond time for its
// device and produces no result. A tick transfer (tuser = 0) advances the
// millisecond time and the beep phase, then scans the last-seen memory one
// entry per cycle through its single read port, checks each device's age
// (modulo 2^32) against timeout_ms, and finally updates the tone and beep
// count and emits one result transfer. From its transfer to the loading of
// its result, a tick passes through acceptance, the memory reads of the scan
// state, the last compare in S_LAST and the tone update in S_DONE. Input is
// taken only while no tick is in work. A finished result waits in an output
// register, so a new item can be taken while the result is still pending
// downstream; a second tick stalls in S_DONE until that register is free.
// Entries that have never seen a heartbeat read as time zero through one
// valid flip-flop per entry, cleared at reset, so no clearing pass is needed.
// Configuration writes must be made while no tick is in work.
module heartbeat_watchdog_beep_code #(
    parameter int DEVICES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, lowest bit up: device[2:0], exception_flag[3], startup_busy[4], zero[7:5]
    input  logic [7:0]  s_axis_tdata,
    // tuser: mode (0 = tick, 1 = heartbeat)
    input  logic        s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, lowest bit up: tone_on[0], tone_note[5:1], offline_mask[13:6],
    // first_offline[16:14], any_offline[17], zero[23:18]
    output logic [23:0] m_axis_tdata
);

    import hbwd_pkg::*;

    localparam int AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int BW = $clog2(DEVICES + 2);

    // Configuration registers.
    logic [15:0] r_timeout;
    logic [9:0]  r_period;

    // Scalar state.
    logic [31:0] r_now;
    logic [9:0]  r_phase;
    logic [BW-1:0] r_beep;
    logic        r_tone_on;
    logic [4:0]  r_tone_note;

    // Tick flags captured at transfer time.
    logic        r_exc;
    logic        r_busy;

    // Last-seen memory and its per-entry valid bits.
    logic [31:0]        mem_seen [DEVICES];
    logic [DEVICES-1:0] r_valid;
    logic [31:0]        r_rd_data;
    logic               r_rd_ok;

    // Scan sequencing.
    t_state      r_state;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] r_cmp_idx;
    logic        r_cmp_vld;

    // Scan accumulators.
    logic [7:0]  r_mask;
    logic [AW-1:0] r_first;
    logic        r_any;

    // Output register.
    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic        in_xfer;
    logic        hb_xfer;
    logic        tick_xfer;
    logic        hb_dev_ok;
    logic [2:0]  in_dev;
    logic        rd_last;
    logic [31:0] cmp_seen;
    logic [31:0] cmp_age;
    logic        cmp_off;
    logic [2:0]  cmp_bit;
    logic        out_free;
    logic        slot_end;
    logic        slot_sound;
    logic [BEEP_MATH_W-1:0] beep_ext;
    logic [BEEP_MATH_W-1:0] beep_inc;
    logic [BEEP_MATH_W-1:0] first_ext;
    logic        n_tone_on;
    logic [4:0]  n_tone_note;
    logic [BW-1:0] n_beep;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign hb_xfer   = in_xfer && (s_axis_tuser == MODE_HEARTBEAT);
    assign tick_xfer = in_xfer && (s_axis_tuser == MODE_TICK);
    assign in_dev    = s_axis_tdata[2:0];
    // The device field can name indexes beyond the configured device count.
    assign hb_dev_ok = (32'(in_dev) < DEVICES);
    assign rd_last   = (32'(r_rd_idx) == DEVICES - 1);

    // Age compare on the registered read data; unwritten entries read as zero.
    assign cmp_seen = r_rd_ok ? r_rd_data : 32'd0;
    assign cmp_age  = r_now - cmp_seen;
    assign cmp_off  = (cmp_age >= {16'd0, r_timeout});
    assign cmp_bit  = 3'(r_cmp_idx);

    assign out_free = !r_out_valid || m_axis_tready;

    // Beep slot decisions use the phase value already advanced by this tick.
    assign slot_end   = (r_phase >= r_period);
    assign slot_sound = ({r_phase, 1'b0} < {1'b0, r_period});
    assign beep_ext   = BEEP_MATH_W'(r_beep);
    assign beep_inc   = beep_ext + BEEP_MATH_W'(1);
    assign first_ext  = BEEP_MATH_W'(r_first);

    // Tone and beep count update, in priority order: busy, fault, none offline,
    // then the beep code for the lowest offline device.
    always_comb begin
        n_tone_on   = r_tone_on;
        n_tone_note = r_tone_note;
        n_beep      = r_beep;
        if (r_busy) begin
            n_tone_on   = r_tone_on;
        end else if (r_exc) begin
            n_tone_on   = 1'b1;
            n_tone_note = 5'd0;
        end else if (!r_any) begin
            n_tone_on   = 1'b0;
            n_tone_note = 5'd0;
        end else begin
            if (slot_sound) begin
                if (beep_ext <= first_ext) begin
                    n_tone_on   = 1'b1;
                    n_tone_note = 5'(r_beep);
                end else begin
                    n_tone_on   = 1'b0;
                    n_tone_note = 5'd0;
                end
            end
            if (slot_end) begin
                // Two silent slots follow the last beep before the count restarts.
                if (beep_inc > first_ext + BEEP_MATH_W'(2)) begin
                    n_beep = '0;
                end else begin
                    n_beep = BW'(beep_inc);
                end
            end
        end
    end

    // Memory: written by heartbeats while idle, read during the scan; the two
    // never happen in the same cycle, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (hb_xfer && hb_dev_ok) begin
            mem_seen[AW'(in_dev)] <= r_now;
        end
        if (r_state == S_SCAN) begin
            r_rd_data <= mem_seen[r_rd_idx];
            r_rd_ok   <= r_valid[r_rd_idx];
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_period    <= PERIOD_RST;
            r_now       <= 32'd0;
            r_phase     <= 10'd0;
            r_beep      <= '0;
            r_tone_on   <= 1'b0;
            r_tone_note <= 5'd0;
            r_valid     <= '0;
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_PERIOD:  r_period  <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end

            // The output register loads a finished result, else empties on a transfer.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            r_cmp_vld <= (r_state == S_SCAN);

            case (r_state)
                S_IDLE: begin
                    if (hb_xfer && hb_dev_ok) begin
                        r_valid[AW'(in_dev)] <= 1'b1;
                    end
                    if (tick_xfer) begin
                        r_now    <= r_now + 32'd1;
                        r_phase  <= r_phase + 10'd1;
                        r_rd_idx <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_last) begin
                        r_state <= S_LAST;
                    end else begin
                        r_rd_idx <= r_rd_idx + AW'(1);
                    end
                end
                S_LAST: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_tone_on   <= n_tone_on;
                        r_tone_note <= n_tone_note;
                        r_beep      <= n_beep;
                        if (slot_end) begin
                            r_phase <= 10'd0;
                        end
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: tick flags, scan accumulators and the result word.
    always_ff @(posedge i_clk) begin
        if (tick_xfer) begin
            r_exc   <= s_axis_tdata[3];
            r_busy  <= s_axis_tdata[4];
            r_mask  <= 8'd0;
            r_first <= '0;
            r_any   <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_cmp_idx <= r_rd_idx;
        end
        if (r_cmp_vld && cmp_off) begin
            if (!r_any) begin
                r_first <= r_cmp_idx;
            end
            r_any <= 1'b1;
            // Devices above seven have no bit in the mask.
            if (32'(r_cmp_idx) < 8) begin
                r_mask[cmp_bit] <= 1'b1;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data <= {6'd0, r_any, 3'(r_first), r_mask, n_tone_note, n_tone_on};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // A silent buzzer always reports note zero.
    a_silent_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tone_on |-> (r_tone_note == 5'd0))
        else $error("tone note nonzero while silent");

    // The beep count never passes the last silent slot of the largest code.
    a_beep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_beep) <= DEVICES + 1)
        else $error("beep count out of range");

    // The scan never addresses beyond the memory depth.
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_rd_idx) < DEVICES))
        else $error("scan read address out of range");

    // A heartbeat for a present device marks its entry as written.
    a_hb_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hb_xfer && hb_dev_ok) |=> r_valid[AW'($past(in_dev))])
        else $error("heartbeat did not mark its entry valid");

    // A tick transfer leads to a scan, not straight back to idle.
    a_tick_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_xfer |=> (r_state == S_SCAN))
        else $error("tick did not start a scan");
`endif

endmodule
